/* rtl/dirty_region_tracker_unit_macros.svh */
// Assertion helpers for the checker file.
// Each macro expects clk_i and rst_ni in scope.
`ifndef DIRTY_REGION_TRACKER_UNIT_MACROS_SVH
`define DIRTY_REGION_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define DRT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("drt: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define DRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("drt: next-cycle check failed");

`endif

/* rtl/drt_pkg.sv */
// ----------------------------------------------------------------------------
// drt_pkg
// Types, codes and defaults shared by the damage rectangle tracker.
// ----------------------------------------------------------------------------
package drt_pkg;

  // Default parameter values
  localparam int unsigned PAGE_BYTES_DEF = 4096;
  localparam int unsigned RING_SLOTS_DEF = 64;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [15:0] LINE_BYTES_RST    = 16'd3200;
  localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd800;
  localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd600;
  localparam logic [12:0] PAGE_COUNT_RST    = 13'd469;

  // Empty-box sentinel for the low edges
  localparam logic [12:0] BOX_EMPTY_LO = 13'h1FFF;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_BYTES    = 3'd0,
    CFG_SCREEN_WIDTH  = 3'd1,
    CFG_SCREEN_HEIGHT = 3'd2,
    CFG_PAGE_COUNT    = 3'd3,
    CFG_UPDATE_ENABLE = 3'd4
  } drt_cfg_e;

  // Request codes
  typedef enum logic [1:0] {
    REQ_DRAW  = 2'd0,
    REQ_FAULT = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NONE  = 2'd3
  } drt_req_e;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_RECORDED  = 3'd0,
    STAT_UPDATE    = 3'd1,
    STAT_DISABLED  = 3'd2,
    STAT_RING_FULL = 3'd3,
    STAT_NOTHING   = 3'd4,
    STAT_BAD_PAGE  = 3'd5
  } drt_status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_COMMIT
  } drt_state_e;

  // Input item
  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] rect_x;
    logic [11:0] rect_y;
    logic [11:0] rect_w;
    logic [11:0] rect_h;
    logic [11:0] page_number;
    logic [31:0] consumer_index;
  } drt_in_t;

  // Result item
  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] update_x;
    logic [12:0] update_y;
    logic [12:0] update_width;
    logic [12:0] update_height;
    logic [31:0] ring_slot;
  } drt_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic div_load;
    logic div_step;
    logic commit;
  } drt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic noop;
    logic need_div;
    logic div_last;
    logic out_free;
  } drt_stat_t;

endpackage

/* rtl/drt_ctrl.sv */
// ----------------------------------------------------------------------------
// drt_ctrl
// Sequencer: captures an item, runs the row divider for in-range page faults and
// commits any result into the output register.
// ----------------------------------------------------------------------------
module drt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  drt_pkg::drt_stat_t  stat_i,
  output drt_pkg::drt_cmd_t   cmd_o
);

  drt_pkg::drt_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= drt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      drt_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = drt_pkg::S_DECIDE;
        end
      end
      drt_pkg::S_DECIDE: begin
        if (stat_i.noop) begin
          state_d = drt_pkg::S_IDLE;
        end else if (stat_i.need_div) begin
          cmd_o.div_load = 1'b1;
          state_d        = drt_pkg::S_DIV;
        end else begin
          state_d = drt_pkg::S_COMMIT;
        end
      end
      drt_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = drt_pkg::S_COMMIT;
        end
      end
      drt_pkg::S_COMMIT: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = drt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = drt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/drt_dpath.sv */
// ----------------------------------------------------------------------------
// drt_dpath
// Datapath: configuration registers, damage box, producer index, a two-lane
// restoring divider for page-to-row mapping and the output register.
// ----------------------------------------------------------------------------
module drt_dpath #(
  parameter int unsigned PAGE_BYTES = drt_pkg::PAGE_BYTES_DEF,
  parameter int unsigned RING_SLOTS = drt_pkg::RING_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  drt_pkg::drt_in_t                  in_data_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output drt_pkg::drt_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [drt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [drt_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  drt_pkg::drt_cmd_t                 cmd_i,
  output drt_pkg::drt_stat_t                stat_o
);

  // Dividend width: (page+1)*PAGE_BYTES-1 with a 12-bit page
  localparam int unsigned DW = 12 + $clog2(PAGE_BYTES);
  localparam int unsigned CW = $clog2(DW + 1);

  // Configuration registers
  logic [15:0] line_bytes_q;
  logic [11:0] screen_width_q;
  logic [11:0] screen_height_q;
  logic [12:0] page_count_q;
  logic        update_enable_q;

  // Tracker state
  logic [12:0] left_q, top_q, right_q, bottom_q;
  logic [12:0] left_d, top_d, right_d, bottom_d;
  logic [31:0] prod_q, prod_d;

  // Captured item
  drt_pkg::drt_in_t req_q;

  // Divider lanes: lane 0 first row, lane 1 last row
  logic [DW-1:0] num_q [2];
  logic [DW-1:0] num_d [2];
  logic [15:0]   rem_q [2];
  logic [15:0]   rem_d [2];
  logic [CW-1:0] cnt_q;

  // Output register
  logic              out_valid_q;
  drt_pkg::drt_out_t out_q, res;

  logic [15:0]   lb_eff;
  logic [DW-1:0] first_byte;
  logic [DW-1:0] last_byte;
  logic          page_ok;
  logic [16:0]   rem_sh [2];
  logic          ge     [2];
  logic [11:0]   row_clamp [2];
  logic [12:0]   gx0, gy0, gx1, gy1;
  logic          do_grow, do_empty, do_emit;
  logic          ring_full, box_empty;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_bytes_q    <= drt_pkg::LINE_BYTES_RST;
      screen_width_q  <= drt_pkg::SCREEN_WIDTH_RST;
      screen_height_q <= drt_pkg::SCREEN_HEIGHT_RST;
      page_count_q    <= drt_pkg::PAGE_COUNT_RST;
      update_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (drt_pkg::drt_cfg_e'(cfg_index_i))
        drt_pkg::CFG_LINE_BYTES:    line_bytes_q    <= cfg_wdata_i;
        drt_pkg::CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata_i[11:0];
        drt_pkg::CFG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata_i[11:0];
        drt_pkg::CFG_PAGE_COUNT:    page_count_q    <= cfg_wdata_i[12:0];
        drt_pkg::CFG_UPDATE_ENABLE: update_enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_data_i;
    end
  end

  // Page bounds and byte span of the faulting page
  assign page_ok    = {1'b0, req_q.page_number} < page_count_q;
  assign lb_eff     = (line_bytes_q == '0) ? 16'd1 : line_bytes_q;
  assign first_byte = DW'(req_q.page_number) * DW'(PAGE_BYTES);
  assign last_byte  = first_byte + DW'(PAGE_BYTES - 1);

  // One restoring step per lane
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem_sh[i] = {rem_q[i], num_q[i][DW-1]};
      ge[i]     = rem_sh[i] >= {1'b0, lb_eff};
      rem_d[i]  = ge[i] ? 16'(rem_sh[i] - {1'b0, lb_eff}) : rem_sh[i][15:0];
      num_d[i]  = {num_q[i][DW-2:0], ge[i]};
      // quotient clamped to the screen height
      row_clamp[i] = (num_q[i] > DW'(screen_height_q)) ? screen_height_q
                                                       : num_q[i][11:0];
    end
  end

  // Divider registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_load) begin
      cnt_q <= CW'(DW);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      num_q[0] <= first_byte;
      num_q[1] <= last_byte;
      rem_q[0] <= '0;
      rem_q[1] <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  // Flush tests
  assign ring_full = (prod_q - req_q.consumer_index) == 32'(RING_SLOTS);
  assign box_empty = (right_q <= left_q) || (bottom_q <= top_q);

  // Result and state update selection
  always_comb begin
    res      = '0;
    do_grow  = 1'b0;
    do_empty = 1'b0;
    do_emit  = 1'b0;
    gx0      = {1'b0, req_q.rect_x};
    gy0      = {1'b0, req_q.rect_y};
    gx1      = 13'({1'b0, req_q.rect_x} + {1'b0, req_q.rect_w});
    gy1      = 13'({1'b0, req_q.rect_y} + {1'b0, req_q.rect_h});
    unique case (drt_pkg::drt_req_e'(req_q.req_type))
      drt_pkg::REQ_DRAW: begin
        res.status = drt_pkg::STAT_RECORDED;
        do_grow    = 1'b1;
      end
      drt_pkg::REQ_FAULT: begin
        gx0 = '0;
        gy0 = {1'b0, row_clamp[0]};
        gx1 = {1'b0, screen_width_q};
        gy1 = {1'b0, row_clamp[1]};
        if (page_ok) begin
          res.status = drt_pkg::STAT_RECORDED;
          do_grow    = 1'b1;
        end else begin
          res.status = drt_pkg::STAT_BAD_PAGE;
        end
      end
      drt_pkg::REQ_FLUSH: begin
        if (!update_enable_q) begin
          res.status = drt_pkg::STAT_DISABLED;
        end else if (ring_full) begin
          res.status = drt_pkg::STAT_RING_FULL;
        end else if (box_empty) begin
          res.status = drt_pkg::STAT_NOTHING;
          do_empty   = 1'b1;
        end else begin
          res.status        = drt_pkg::STAT_UPDATE;
          res.update_x      = left_q;
          res.update_y      = top_q;
          res.update_width  = right_q - left_q;
          res.update_height = bottom_q - top_q;
          res.ring_slot     = prod_q;
          do_empty          = 1'b1;
          do_emit           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Next box and producer index
  always_comb begin
    left_d   = left_q;
    top_d    = top_q;
    right_d  = right_q;
    bottom_d = bottom_q;
    prod_d   = prod_q;
    if (do_grow) begin
      if (gx0 < left_q)   left_d   = gx0;
      if (gy0 < top_q)    top_d    = gy0;
      if (gx1 > right_q)  right_d  = gx1;
      if (gy1 > bottom_q) bottom_d = gy1;
    end
    if (do_empty) begin
      left_d   = drt_pkg::BOX_EMPTY_LO;
      top_d    = drt_pkg::BOX_EMPTY_LO;
      right_d  = '0;
      bottom_d = '0;
    end
    if (do_emit) begin
      prod_d = prod_q + 32'd1;
    end
  end

  // Tracker state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= drt_pkg::BOX_EMPTY_LO;
      top_q    <= drt_pkg::BOX_EMPTY_LO;
      right_q  <= '0;
      bottom_q <= '0;
      prod_q   <= '0;
    end else if (cmd_i.commit) begin
      left_q   <= left_d;
      top_q    <= top_d;
      right_q  <= right_d;
      bottom_q <= bottom_d;
      prod_q   <= prod_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status to the controller
  assign stat_o.noop     = req_q.req_type == drt_pkg::REQ_NONE;
  assign stat_o.need_div = (req_q.req_type == drt_pkg::REQ_FAULT) && page_ok;
  assign stat_o.div_last = cnt_q == CW'(1);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

endmodule

/* rtl/dirty_region_tracker_unit.sv */
// Flow: an accepted item passes S_DECIDE; a valid page fault then runs the row
//   divider in S_DIV over a DW = 12 + clog2(PAGE_BYTES) bit dividend; then
//   S_COMMIT loads the output register. An unknown request leaves no result.
//   One item at a time; a result still held at commit stalls the next item.
// Reset: asynchronous, clears the box, producer index and output valid and
//   loads the configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// dirty_region_tracker_unit
// Screen damage rectangle tracker: grows a bounding box from draw and page
// fault items and hands it to a remote ring on flush.
// ----------------------------------------------------------------------------
module dirty_region_tracker_unit #(
  parameter int unsigned PAGE_BYTES = drt_pkg::PAGE_BYTES_DEF,
  parameter int unsigned RING_SLOTS = drt_pkg::RING_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  drt_pkg::drt_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output drt_pkg::drt_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [drt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [drt_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  drt_pkg::drt_cmd_t  cmd;
  drt_pkg::drt_stat_t stat;

  // Sequencer
  drt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath
  drt_dpath #(
    .PAGE_BYTES (PAGE_BYTES),
    .RING_SLOTS (RING_SLOTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

/* rtl/drt_checker.sv */
// ----------------------------------------------------------------------------
// drt_checker
// Port-level checks for the damage rectangle tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "dirty_region_tracker_unit_macros.svh"

module drt_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_o,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  drt_pkg::drt_out_t              out_data_o
);

  logic in_xfer;
  logic out_held;
  logic no_update;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_held  = out_valid_o && out_stall_i;
  assign no_update = out_data_o.status != drt_pkg::STAT_UPDATE;

  // A stalled result holds its value
  `DRT_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(out_data_o))

  // The block works on one item at a time after a transfer
  `DRT_ASSERT_NEXT(a_busy_after_take, in_xfer, in_stall_o)

  // Only an emitted update carries geometry and a ring slot
  `DRT_ASSERT_IMPL(a_zero_fields, out_valid_o && no_update,
    out_data_o.update_x == '0 && out_data_o.update_y == '0 &&
    out_data_o.update_width == '0 && out_data_o.update_height == '0 &&
    out_data_o.ring_slot == '0)

  // Status stays within the defined codes
  `DRT_ASSERT_IMPL(a_status_code, out_valid_o, out_data_o.status <= drt_pkg::STAT_BAD_PAGE)

endmodule

bind dirty_region_tracker_unit drt_checker u_drt_checker (.*);

/* tb/dirty_region_tracker_unit_tb.sv */
// ----------------------------------------------------------------------------
// dirty_region_tracker_unit_tb
// Self-checking bench for the damage rectangle tracker. A predictor class
// keeps its own copy of the box, producer index and registers, works out the
// status and update for every accepted request, and checks each result
// transfer against the oldest prediction. Directed requests cover the corner
// cases, then random phases run under several register settings, most of them with
// random idle cycles on both channels.
// ----------------------------------------------------------------------------
module dirty_region_tracker_unit_tb;

  localparam int unsigned IDLE_PCT     = 19;
  localparam int unsigned PHASE_ITEMS  = 245;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // Predicts tracker results and checks them in order
  class damage_box_predictor;
    logic [15:0]        line_bytes;
    logic [11:0]        screen_width;
    logic [11:0]        screen_height;
    logic [12:0]        page_count;
    logic               update_en;
    logic [12:0]        box_left;
    logic [12:0]        box_top;
    logic [12:0]        box_right;
    logic [12:0]        box_bottom;
    logic [31:0]        producer;
    drt_pkg::drt_out_t  expected_results[$];
    int unsigned        mismatches;

    function new();
      line_bytes    = drt_pkg::LINE_BYTES_RST;
      screen_width  = drt_pkg::SCREEN_WIDTH_RST;
      screen_height = drt_pkg::SCREEN_HEIGHT_RST;
      page_count    = drt_pkg::PAGE_COUNT_RST;
      update_en     = 1'b0;
      producer      = '0;
      mismatches    = 0;
      clear_box();
    endfunction

    function void set_config(logic [15:0] lb, logic [11:0] sw, logic [11:0] sh,
                             logic [12:0] pc, logic en);
      line_bytes    = lb;
      screen_width  = sw;
      screen_height = sh;
      page_count    = pc;
      update_en     = en;
    endfunction

    function void clear_box();
      box_left   = drt_pkg::BOX_EMPTY_LO;
      box_top    = drt_pkg::BOX_EMPTY_LO;
      box_right  = '0;
      box_bottom = '0;
    endfunction

    function void grow_box(logic [12:0] x0, logic [12:0] y0,
                           logic [12:0] x1, logic [12:0] y1);
      if (x0 < box_left)   box_left   = x0;
      if (y0 < box_top)    box_top    = y0;
      if (x1 > box_right)  box_right  = x1;
      if (y1 > box_bottom) box_bottom = y1;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Work out the result of one accepted request
    function void note_request(drt_pkg::drt_in_t req);
      drt_pkg::drt_out_t res;
      logic [63:0]       divisor;
      logic [63:0]       first_byte;
      logic [63:0]       row0;
      logic [63:0]       row1;
      logic [31:0]       in_flight;
      // unknown requests leave no result behind
      if (req.req_type == drt_pkg::REQ_NONE) return;
      res = '0;
      case (req.req_type)
        drt_pkg::REQ_DRAW: begin
          grow_box({1'b0, req.rect_x}, {1'b0, req.rect_y},
                   {1'b0, req.rect_x} + {1'b0, req.rect_w},
                   {1'b0, req.rect_y} + {1'b0, req.rect_h});
          res.status = drt_pkg::STAT_RECORDED;
        end
        drt_pkg::REQ_FAULT: begin
          if ({1'b0, req.page_number} >= page_count) begin
            res.status = drt_pkg::STAT_BAD_PAGE;
          end else begin
            // zero line length divides by one
            divisor    = (line_bytes == '0) ? 64'd1 : 64'(line_bytes);
            first_byte = 64'(req.page_number) * 64'(drt_pkg::PAGE_BYTES_DEF);
            row0 = first_byte / divisor;
            row1 = (first_byte + 64'(drt_pkg::PAGE_BYTES_DEF) - 64'd1) / divisor;
            if (row0 > 64'(screen_height)) row0 = 64'(screen_height);
            if (row1 > 64'(screen_height)) row1 = 64'(screen_height);
            grow_box('0, row0[12:0], {1'b0, screen_width}, row1[12:0]);
            res.status = drt_pkg::STAT_RECORDED;
          end
        end
        default: begin
          in_flight = producer - req.consumer_index;
          if (!update_en) begin
            res.status = drt_pkg::STAT_DISABLED;
          end else if (in_flight == 32'(drt_pkg::RING_SLOTS_DEF)) begin
            res.status = drt_pkg::STAT_RING_FULL;
          end else if (box_right <= box_left || box_bottom <= box_top) begin
            clear_box();
            res.status = drt_pkg::STAT_NOTHING;
          end else begin
            res.update_x      = box_left;
            res.update_y      = box_top;
            res.update_width  = box_right - box_left;
            res.update_height = box_bottom - box_top;
            res.ring_slot     = producer;
            producer          = producer + 32'd1;
            clear_box();
            res.status = drt_pkg::STAT_UPDATE;
          end
        end
      endcase
      expected_results.push_back(res);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s: got %0h, want %0h", name, got, want));
    endtask

    // Check one result transfer against the oldest prediction
    task check_update(drt_pkg::drt_out_t got);
      drt_pkg::drt_out_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h", got));
      end else begin
        want = expected_results.pop_front();
        compare_field("status", 32'(got.status), 32'(want.status));
        compare_field("update_x", 32'(got.update_x), 32'(want.update_x));
        compare_field("update_y", 32'(got.update_y), 32'(want.update_y));
        compare_field("update_width", 32'(got.update_width), 32'(want.update_width));
        compare_field("update_height", 32'(got.update_height), 32'(want.update_height));
        compare_field("ring_slot", got.ring_slot, want.ring_slot);
      end
    endtask

    task flag_leftovers();
      if (expected_results.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    endtask
  endclass

  logic                           clk_i;
  logic                           rst_ni    = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall_o;
  drt_pkg::drt_in_t               in_data   = '0;
  logic                           out_valid_o;
  logic                           out_stall = 1'b0;
  drt_pkg::drt_out_t              out_data_o;
  logic                           cfg_we    = 1'b0;
  logic [drt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [drt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           gaps_on   = 1'b1;
  int unsigned                    cycles    = 0;

  damage_box_predictor damage = new();

  dirty_region_tracker_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("dirty_region_tracker_unit regression: fail");
      $finish;
    end
  end

  // Result side: random stall, check every transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) damage.check_update(out_data_o);
      out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Offer one request and hold it until the transfer happens
  task automatic send_request(drt_pkg::drt_in_t req);
    if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (in_stall_o);
    damage.note_request(req);
  endtask

  // Let every pending result drain, then give the block time to go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (damage.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [15:0] lb, logic [11:0] sw, logic [11:0] sh,
                               logic [12:0] pc, logic en);
    cfg_we    <= 1'b1;
    cfg_index <= drt_pkg::CFG_LINE_BYTES;
    cfg_wdata <= lb;
    @(posedge clk_i);
    cfg_index <= drt_pkg::CFG_SCREEN_WIDTH;
    cfg_wdata <= 16'(sw);
    @(posedge clk_i);
    cfg_index <= drt_pkg::CFG_SCREEN_HEIGHT;
    cfg_wdata <= 16'(sh);
    @(posedge clk_i);
    cfg_index <= drt_pkg::CFG_PAGE_COUNT;
    cfg_wdata <= 16'(pc);
    @(posedge clk_i);
    cfg_index <= drt_pkg::CFG_UPDATE_ENABLE;
    cfg_wdata <= 16'(en);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    damage.set_config(lb, sw, sh, pc, en);
  endtask

  function automatic drt_pkg::drt_in_t make_request(drt_pkg::drt_req_e kind,
                                                    int unsigned x, int unsigned y,
                                                    int unsigned w, int unsigned h,
                                                    int unsigned page,
                                                    logic [31:0] cons);
    drt_pkg::drt_in_t r;
    r.req_type       = kind;
    r.rect_x         = 12'(x);
    r.rect_y         = 12'(y);
    r.rect_w         = 12'(w);
    r.rect_h         = 12'(h);
    r.page_number    = 12'(page);
    r.consumer_index = cons;
    return r;
  endfunction

  // Mostly well-formed traffic with random content, some noise
  function automatic drt_pkg::drt_in_t random_request();
    drt_pkg::drt_in_t r;
    int unsigned      pick;
    int unsigned      top_page;
    r.rect_x         = 12'($urandom);
    r.rect_y         = 12'($urandom);
    r.rect_w         = 12'($urandom);
    r.rect_h         = 12'($urandom);
    r.page_number    = 12'($urandom);
    r.consumer_index = $urandom;
    pick = $urandom_range(99);
    if (pick < 5) begin
      r.req_type = drt_pkg::REQ_NONE;
    end else if (pick < 45) begin
      r.req_type = drt_pkg::REQ_DRAW;
      if ($urandom_range(1)) begin
        r.rect_w = 12'($urandom_range(255));
        r.rect_h = 12'($urandom_range(255));
      end
    end else if (pick < 70) begin
      r.req_type = drt_pkg::REQ_FAULT;
      if (damage.page_count != '0 && $urandom_range(99) < 85) begin
        top_page = int'(damage.page_count) - 1;
        if (top_page > 4095) top_page = 4095;
        r.page_number = 12'($urandom_range(top_page));
      end
    end else begin
      r.req_type = drt_pkg::REQ_FLUSH;
      pick = $urandom_range(99);
      if (pick < 70)
        r.consumer_index = damage.producer -
                           32'($urandom_range(drt_pkg::RING_SLOTS_DEF - 1));
      else if (pick < 85)
        r.consumer_index = damage.producer - 32'(drt_pkg::RING_SLOTS_DEF);
    end
    return r;
  endfunction

  task automatic random_phase();
    int unsigned      sent;
    drt_pkg::drt_in_t req;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      req = random_request();
      send_request(req);
      if (req.req_type != drt_pkg::REQ_NONE) sent++;
    end
    settle();
  endtask

  initial begin
    int unsigned guard;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: updates disabled
    send_request(make_request(drt_pkg::REQ_DRAW, 0, 0, 0, 0, 0, 0));
    send_request(make_request(drt_pkg::REQ_FAULT, 0, 0, 0, 0, 0, 0));
    send_request(make_request(drt_pkg::REQ_FLUSH, 0, 0, 0, 0, 0, 0));
    send_request(make_request(drt_pkg::REQ_FAULT, 0, 0, 0, 0, 469, 0));
    send_request(make_request(drt_pkg::REQ_NONE, 4095, 4095, 4095, 4095, 4095,
                              32'hFFFF_FFFF));
    settle();

    // Updates on: emit, empty flush, widest box, ring full and wrapped index
    apply_setting(16'd3200, 12'd800, 12'd600, 13'd469, 1'b1);
    send_request(make_request(drt_pkg::REQ_FLUSH, 0, 0, 0, 0, 0, damage.producer));
    send_request(make_request(drt_pkg::REQ_FLUSH, 0, 0, 0, 0, 0, damage.producer));
    send_request(make_request(drt_pkg::REQ_DRAW, 4095, 4095, 4095, 4095, 0, 0));
    send_request(make_request(drt_pkg::REQ_DRAW, 0, 0, 0, 0, 0, 0));
    send_request(make_request(drt_pkg::REQ_FLUSH, 0, 0, 0, 0, 0,
                              damage.producer - 32'(drt_pkg::RING_SLOTS_DEF)));
    send_request(make_request(drt_pkg::REQ_FLUSH, 0, 0, 0, 0, 0,
                              damage.producer + 32'd1));
    send_request(make_request(drt_pkg::REQ_FAULT, 0, 0, 0, 0, 468, 0));
    send_request(make_request(drt_pkg::REQ_FLUSH, 0, 0, 0, 0, 0,
                              damage.producer - 32'(drt_pkg::RING_SLOTS_DEF - 1)));
    send_request(make_request(drt_pkg::REQ_DRAW, 10, 10, 0, 5, 0, 0));
    send_request(make_request(drt_pkg::REQ_FLUSH, 0, 0, 0, 0, 0, damage.producer));
    settle();

    // Zero line length; a page past the screen gives an empty span at the bottom
    apply_setting(16'd0, 12'd4095, 12'd4095, 13'd4096, 1'b1);
    send_request(make_request(drt_pkg::REQ_FAULT, 0, 0, 0, 0, 4095, 0));
    send_request(make_request(drt_pkg::REQ_FLUSH, 0, 0, 0, 0, 0, damage.producer));
    send_request(make_request(drt_pkg::REQ_FAULT, 0, 0, 0, 0, 0, 0));
    send_request(make_request(drt_pkg::REQ_FLUSH, 0, 0, 0, 0, 0, damage.producer));
    settle();

    // No pages at all, tiny screen
    apply_setting(16'd65535, 12'd1, 12'd1, 13'd0, 1'b1);
    send_request(make_request(drt_pkg::REQ_FAULT, 0, 0, 0, 0, 0, 0));
    send_request(make_request(drt_pkg::REQ_DRAW, 1, 2, 3, 4, 0, 0));
    send_request(make_request(drt_pkg::REQ_FLUSH, 0, 0, 0, 0, 0, damage.producer));
    settle();

    // Random phases across settings; one phase runs without idle cycles
    apply_setting(16'd3200, 12'd800, 12'd600, 13'd469, 1'b1);
    random_phase();
    gaps_on <= 1'b0;
    apply_setting(16'd1, 12'd4095, 12'd4095, 13'd4096, 1'b1);
    random_phase();
    gaps_on <= 1'b1;
    apply_setting(16'd65535, 12'd1, 12'd1, 13'd4096, 1'b1);
    random_phase();
    apply_setting(16'($urandom_range(6000, 1)), 12'($urandom_range(4095, 1)),
                  12'($urandom_range(4095, 1)), 13'($urandom_range(4096)), 1'b1);
    random_phase();
    apply_setting(16'($urandom_range(65535, 1)), 12'($urandom_range(4095, 1)),
                  12'($urandom_range(4095, 1)), 13'($urandom_range(4096)),
                  $urandom_range(99) < 80);
    random_phase();

    // Bounded wait for stragglers, then the verdict
    guard = 0;
    while (damage.pending() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    damage.flag_leftovers();
    if (damage.mismatches == 0) $display("dirty_region_tracker_unit regression: pass");
    else $display("dirty_region_tracker_unit regression: fail");
    $finish;
  end

endmodule
